>>> sv/matrix_local_maximum_finder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix local maximum finder
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_LOCAL_MAXIMUM_FINDER_UNIT_MACROS_SVH
`define MATRIX_LOCAL_MAXIMUM_FINDER_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define MLMF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define MLMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/mlmf_pkg.sv
// ----------------------------------------------------------------------------
// mlmf_pkg
// Types and constants shared by the local maximum finder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mlmf_pkg;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SAMPLE_IN_W  = 16;
  localparam int ROW_W        = 12;
  localparam int COL_OUT_W    = 10;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_PAD_W    = OUT_TDATA_W - ROW_W - COL_OUT_W;

  localparam int ROWS_CFG_W   = 13;
  localparam int COLS_CFG_W   = 11;
  localparam int ROWS_LIMIT   = 4096;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_ADDR_W   = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COLS = 1'b1;

  // results one input can cause, and the result queue behind them
  localparam int MAX_RES   = 3;
  localparam int PUSH_W    = 2;
  localparam int OQ_DEPTH  = 8;
  localparam int OQ_PTR_W  = 3;
  localparam int OQ_CNT_W  = 4;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [OQ_CNT_W-1:0] count;
    logic                room;
  } oq_stat_t;

endpackage

`default_nettype wire

>>> sv/mlmf_cell.sv
// ----------------------------------------------------------------------------
// mlmf_cell
// One cell of the sample window: takes its neighbor's value on a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mlmf_cell #(
  parameter int W = mlmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  assign val_nxt = en ? d : val_r;

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

`default_nettype wire

>>> sv/mlmf_linebuf.sv
// ----------------------------------------------------------------------------
// mlmf_linebuf
// Line buffer: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module mlmf_linebuf #(
  parameter int DEPTH = mlmf_pkg::MAX_COLS_DEF,
  parameter int W     = 2 * mlmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // same-address read returns the word being written
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/mlmf_outq.sv
// ----------------------------------------------------------------------------
// mlmf_outq
// Result queue: up to three results in per cycle, one out while head_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mlmf_outq (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic [mlmf_pkg::PUSH_W-1:0]                 push_n,
  input  mlmf_pkg::res_t [mlmf_pkg::MAX_RES-1:0]      push_items,
  output mlmf_pkg::res_t                              head,
  output logic                                        head_valid,
  input  logic                                        head_ready,
  output mlmf_pkg::oq_stat_t                          stat
);

  mlmf_pkg::res_t mem_r [mlmf_pkg::OQ_DEPTH];

  logic [mlmf_pkg::OQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mlmf_pkg::OQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mlmf_pkg::OQ_CNT_W-1:0] count_r, count_nxt;
  logic                          pop;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + mlmf_pkg::OQ_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + mlmf_pkg::OQ_PTR_W'(pop);
    count_nxt  = count_r + mlmf_pkg::OQ_CNT_W'(push_n) - mlmf_pkg::OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mlmf_pkg::MAX_RES; k++) begin
      if (mlmf_pkg::PUSH_W'(k) < push_n) begin
        mem_r[wr_ptr_r + mlmf_pkg::OQ_PTR_W'(k)] <= push_items[k];
      end
    end
  end

  // room for the worst case of one transfer
  assign stat.count = count_r;
  assign stat.room  = (count_r <= mlmf_pkg::OQ_CNT_W'(mlmf_pkg::OQ_DEPTH - mlmf_pkg::MAX_RES));

endmodule

`default_nettype wire

>>> sv/matrix_local_maximum_finder_unit.sv
// ----------------------------------------------------------------------------
// matrix_local_maximum_finder_unit
// Streams a frame of signed samples in raster order and reports the position
// of every sample that is >= each of its existing 4-neighbors.
// ----------------------------------------------------------------------------
//   channel  dir  width  contents
//   in_*     in   16     tdata[15:0] sample_value
//   out_*    out  24     tdata[11:0] peak_row, [21:12] peak_col; tlast last_of_run
//   cfg_*    in   1+13   addr 0 frame_rows, addr 1 frame_cols
//
// one sample per cycle while in_tready is high; each sample is decided when
// its last neighbor arrives, in the same cycle that neighbor is transferred in
// results leave an 8-entry queue at one per cycle while out_tready is high;
// in_tready drops while fewer than three entries are free (the last row can
// cause three per sample); the line buffer does one write and at most one
// look-ahead read per transfer; reset is synchronous; the line buffer is not
// cleared, a register write restarts the frame at row 0, column 0
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_local_maximum_finder_unit_macros.svh"

module matrix_local_maximum_finder_unit #(
  parameter int MAX_COLS    = mlmf_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = mlmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mlmf_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] sample_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mlmf_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [11:0] peak_row, [21:12] peak_col
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [mlmf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mlmf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int SB = SAMPLE_BITS;
  localparam int WW = 2 * SAMPLE_BITS;
  localparam int RW = mlmf_pkg::ROW_W;

  // frame size and position
  logic [RW-1:0] row_last_r, row_last_nxt;
  logic [RW-1:0] row_count_r, row_count_nxt;
  logic [CW-1:0] col_last_r, col_last_nxt;
  logic [CW-1:0] col_count_r, col_count_nxt;

  logic [mlmf_pkg::ROWS_CFG_W-1:0] rows_v;
  logic [mlmf_pkg::COLS_CFG_W-1:0] cols_v;

  logic in_acc;
  logic wrap;

  // window of samples around the current position
  logic [mlmf_pkg::SAMPLE_IN_W+SB-1:0] x_ext;
  logic signed [SB-1:0] x, up, tb, ur, ul, lc, l2;
  logic [WW-1:0] wr_word, rd_word, above_q, above_d, head_q;
  logic [CW:0]   nc1;
  logic          rd_en;

  logic r_ge1, r_ge2, c_ge1, c_ge2, last_row;
  logic hit_up, hit_left, hit_cur;

  logic [CW+mlmf_pkg::COL_OUT_W-1:0] col_ext, colm1_ext;
  logic [CW-1:0]                     col_m1;

  mlmf_pkg::res_t [mlmf_pkg::MAX_RES-1:0] cand, items;
  logic [mlmf_pkg::MAX_RES-1:0]           hits;
  logic [mlmf_pkg::PUSH_W-1:0]            n_hit;
  logic [mlmf_pkg::PUSH_W-1:0]            push_n;

  mlmf_pkg::res_t     head;
  logic               head_valid;
  mlmf_pkg::oq_stat_t q_stat;

  assign in_acc = in_tvalid && in_tready;
  assign wrap   = (col_count_r == col_last_r);

  // ---------------------------------------------------------------------------
  // configuration and position counters
  // ---------------------------------------------------------------------------
  assign rows_v = cfg_wdata[mlmf_pkg::ROWS_CFG_W-1:0];
  assign cols_v = cfg_wdata[mlmf_pkg::COLS_CFG_W-1:0];

  always_comb begin
    row_last_nxt  = row_last_r;
    col_last_nxt  = col_last_r;
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    priority if (cfg_we) begin
      unique case (cfg_addr)
        mlmf_pkg::REG_FRAME_ROWS: begin
          if (rows_v == '0) begin
            row_last_nxt = '0;
          end else if (32'(rows_v) > mlmf_pkg::ROWS_LIMIT) begin
            row_last_nxt = RW'(mlmf_pkg::ROWS_LIMIT - 1);
          end else begin
            row_last_nxt = RW'(rows_v - mlmf_pkg::ROWS_CFG_W'(1));
          end
        end
        mlmf_pkg::REG_FRAME_COLS: begin
          if (cols_v == '0) begin
            col_last_nxt = '0;
          end else if (32'(cols_v) > MAX_COLS) begin
            col_last_nxt = CW'(MAX_COLS - 1);
          end else begin
            col_last_nxt = CW'(cols_v - mlmf_pkg::COLS_CFG_W'(1));
          end
        end
        default: begin
          row_last_nxt = row_last_r;
        end
      endcase
      row_count_nxt = '0;
      col_count_nxt = '0;
    end else if (in_acc) begin
      if (wrap) begin
        col_count_nxt = '0;
        row_count_nxt = (row_count_r == row_last_r) ? '0 : row_count_r + RW'(1);
      end else begin
        col_count_nxt = col_count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_last_r  <= '0;
      col_last_r  <= '0;
      row_count_r <= '0;
      col_count_r <= '0;
    end else begin
      row_last_r  <= row_last_nxt;
      col_last_r  <= col_last_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // sample window: current row to the left, row above around this column
  // ---------------------------------------------------------------------------
  assign x_ext = {{SB{1'b0}}, in_tdata[mlmf_pkg::SAMPLE_IN_W-1:0]};
  assign x     = x_ext[SB-1:0];

  // line buffer word: upper half two rows back, lower half the row above
  assign wr_word = {up, x};
  assign up      = above_q[SB-1:0];
  assign tb      = above_q[WW-1:SB];
  assign ur      = rd_word[SB-1:0];

  // look ahead one column past the next position
  assign nc1   = wrap ? (CW+1)'(1) : {1'b0, col_count_r} + (CW+1)'(2);
  assign rd_en = in_acc && (nc1 <= {1'b0, col_last_r});

  // at a row wrap the column-0 word comes from the head cell (from wr_word if one column)
  assign above_d = !wrap ? rd_word :
                   ((col_count_r == '0) ? wr_word : head_q);

  mlmf_linebuf #(
    .DEPTH (MAX_COLS),
    .W     (WW)
  ) u_linebuf (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (col_count_r),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (nc1[CW-1:0]),
    .rd_data (rd_word)
  );

  mlmf_cell #(.W(WW)) u_above (
    .clk (clk),
    .en  (in_acc),
    .d   (above_d),
    .q   (above_q)
  );

  mlmf_cell #(.W(WW)) u_head (
    .clk (clk),
    .en  (in_acc && (col_count_r == '0)),
    .d   (wr_word),
    .q   (head_q)
  );

  mlmf_cell #(.W(SB)) u_upleft (
    .clk (clk),
    .en  (in_acc),
    .d   (up),
    .q   (ul)
  );

  mlmf_cell #(.W(SB)) u_left1 (
    .clk (clk),
    .en  (in_acc),
    .d   (x),
    .q   (lc)
  );

  mlmf_cell #(.W(SB)) u_left2 (
    .clk (clk),
    .en  (in_acc),
    .d   (lc),
    .q   (l2)
  );

  // ---------------------------------------------------------------------------
  // neighbor compares
  // ---------------------------------------------------------------------------
  always_comb begin
    r_ge1    = (row_count_r != '0);
    r_ge2    = (row_count_r > RW'(1));
    c_ge1    = (col_count_r != '0);
    c_ge2    = (col_count_r > CW'(1));
    last_row = (row_count_r == row_last_r);

    // sample above is complete once its lower neighbor arrives
    hit_up   = r_ge1 && (up >= x) && (!r_ge2 || (up >= tb)) &&
               (!c_ge1 || (up >= ul)) && (wrap || (up >= ur));
    // last row: the left sample is complete with its right neighbor
    hit_left = last_row && c_ge1 && (lc >= x) && (!c_ge2 || (lc >= l2)) &&
               (!r_ge1 || (lc >= ul));
    // final sample of the frame
    hit_cur  = last_row && wrap && (!c_ge1 || (x >= lc)) && (!r_ge1 || (x >= up));
  end

  assign col_m1    = col_count_r - CW'(1);
  assign col_ext   = {{mlmf_pkg::COL_OUT_W{1'b0}}, col_count_r};
  assign colm1_ext = {{mlmf_pkg::COL_OUT_W{1'b0}}, col_m1};

  always_comb begin
    cand[0].row  = row_count_r - RW'(1);
    cand[0].col  = col_ext[mlmf_pkg::COL_OUT_W-1:0];
    cand[0].last = !hit_left && !hit_cur;
    cand[1].row  = row_count_r;
    cand[1].col  = colm1_ext[mlmf_pkg::COL_OUT_W-1:0];
    cand[1].last = !hit_cur;
    cand[2].row  = row_count_r;
    cand[2].col  = col_ext[mlmf_pkg::COL_OUT_W-1:0];
    cand[2].last = 1'b1;
  end

  assign hits = {hit_cur, hit_left, hit_up};

  // pack hits into raster order
  always_comb begin
    items = '0;
    n_hit = '0;
    for (int k = 0; k < mlmf_pkg::MAX_RES; k++) begin
      if (hits[k]) begin
        items[n_hit] = cand[k];
        n_hit        = n_hit + mlmf_pkg::PUSH_W'(1);
      end
    end
  end

  assign push_n = in_acc ? n_hit : '0;

  mlmf_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_items (items),
    .head       (head),
    .head_valid (head_valid),
    .head_ready (out_tready && rst_n),
    .stat       (q_stat)
  );

  assign in_tready  = rst_n && q_stat.room;
  assign out_tvalid = rst_n && head_valid;
  assign out_tdata  = {{mlmf_pkg::OUT_PAD_W{1'b0}}, head.col, head.row};
  assign out_tlast  = head.last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `MLMF_ASSERT_ALWAYS(a_pos_in_frame, (col_count_r <= col_last_r) && (row_count_r <= row_last_r), "position outside frame")
  `MLMF_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= mlmf_pkg::OQ_CNT_W'(mlmf_pkg::OQ_DEPTH), "result queue overflow")
  `MLMF_ASSERT_NEXT(a_col_wrap, in_acc && !cfg_we && wrap, col_count_r == '0, "column did not wrap at row end")

endmodule

`default_nettype wire

>>> verif/tb_matrix_local_maximum_finder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_local_maximum_finder_unit
// Self-checking bench for the 4-neighbor local maximum finder. Streams frames
// of random and directed samples through the input channel. Random gaps and
// stalls are applied on both channels. A behavioral peak tracker, or the hit
// typed into a directed step, predicts what each sample transfer reveals, and
// every output transfer is compared in order against it. Frame sizes change
// between bursts, including zero and oversize settings that the block clamps.
// ----------------------------------------------------------------------------
module tb_matrix_local_maximum_finder_unit;

  localparam int SETTLE      = 16;
  localparam int TAIL        = 20;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic {STEP_SAMPLE, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t                      kind;
    logic [mlmf_pkg::CFG_ADDR_W-1:0] addr;
    logic [15:0]                     value;  // sample, or register data
    bit                              typed;
    mlmf_pkg::res_t                  hit;
  } step_t;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [mlmf_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [mlmf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  logic                             cfg_we     = 1'b0;
  logic [mlmf_pkg::CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [mlmf_pkg::CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // peak tracker state
  logic signed [15:0]              prev_line [0:mlmf_pkg::MAX_COLS_DEF-1];
  logic signed [15:0]              two_back  [0:mlmf_pkg::MAX_COLS_DEF-1];
  logic signed [15:0]              left_cur  = '0;
  logic signed [15:0]              left_up   = '0;
  int                              row_pos   = 0;
  int                              col_pos   = 0;
  logic [mlmf_pkg::ROWS_CFG_W-1:0] rows_reg  = 13'd1;
  logic [mlmf_pkg::COLS_CFG_W-1:0] cols_reg  = 11'd1;

  mlmf_pkg::res_t peak_fifo [$];
  mlmf_pkg::res_t step_peaks [0:mlmf_pkg::MAX_RES-1];
  bit             typed_on   = 1'b0;
  mlmf_pkg::res_t typed_hit  = '0;
  bit             steady_run = 1'b0;
  int             err_cnt    = 0;
  int             quiet_cycles = 0;

  step_t plan [0:28] = '{
    // after reset the frame is one sample, each one its own peak
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h8000, 1'b1, '{12'd0, 10'd0, 1'b1}},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h7fff, 1'b1, '{12'd0, 10'd0, 1'b1}},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0000, 1'b1, '{12'd0, 10'd0, 1'b1}},
    // zero sizes clamp to one
    '{STEP_REG,    mlmf_pkg::REG_FRAME_ROWS, 16'd0,    1'b0, '0},
    '{STEP_REG,    mlmf_pkg::REG_FRAME_COLS, 16'd0,    1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'hffff, 1'b1, '{12'd0, 10'd0, 1'b1}},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0001, 1'b1, '{12'd0, 10'd0, 1'b1}},
    // 3x3 frame with ties and both sign extremes
    '{STEP_REG,    mlmf_pkg::REG_FRAME_ROWS, 16'd3,    1'b0, '0},
    '{STEP_REG,    mlmf_pkg::REG_FRAME_COLS, 16'd3,    1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0005, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0003, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0005, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0003, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0007, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0007, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h8000, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h7fff, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h8000, 1'b0, '0},
    // single row
    '{STEP_REG,    mlmf_pkg::REG_FRAME_ROWS, 16'd1,    1'b0, '0},
    '{STEP_REG,    mlmf_pkg::REG_FRAME_COLS, 16'd4,    1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0002, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0002, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0001, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0003, 1'b0, '0},
    // single column
    '{STEP_REG,    mlmf_pkg::REG_FRAME_ROWS, 16'd3,    1'b0, '0},
    '{STEP_REG,    mlmf_pkg::REG_FRAME_COLS, 16'd1,    1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0001, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0004, 1'b0, '0},
    '{STEP_SAMPLE, mlmf_pkg::REG_FRAME_ROWS, 16'h0004, 1'b0, '0}
  };

  matrix_local_maximum_finder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // positions revealed by one sample, in raster order, into step_peaks
  task automatic find_peaks(input logic signed [15:0] x, output int n);
    int rows, cols, r, c;
    logic signed [15:0] up, v;
    bit ok;
    rows = (rows_reg == 0) ? 1 :
           (rows_reg > mlmf_pkg::ROWS_LIMIT) ? mlmf_pkg::ROWS_LIMIT : int'(rows_reg);
    cols = (cols_reg == 0) ? 1 :
           (cols_reg > mlmf_pkg::MAX_COLS_DEF) ? mlmf_pkg::MAX_COLS_DEF : int'(cols_reg);
    r = row_pos;
    c = col_pos;
    n = 0;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    up = (r >= 1) ? prev_line[c] : 16'sh8000;
    // sample above now has its down neighbor
    if (r >= 1) begin
      ok = (up >= x);
      if (r >= 2 && up < two_back[c]) ok = 1'b0;
      if (c >= 1 && up < left_up) ok = 1'b0;
      if (c + 1 < cols && up < prev_line[c + 1]) ok = 1'b0;
      if (ok) begin
        step_peaks[n] = '{12'(r - 1), 10'(c), 1'b0};
        n++;
      end
    end
    if (r == rows - 1) begin
      // last row: left sample now has its right neighbor
      if (c >= 1) begin
        v = left_cur;
        ok = (v >= x);
        if (c >= 2 && v < prev_line[c - 2]) ok = 1'b0;
        if (r >= 1 && v < two_back[c - 1]) ok = 1'b0;
        if (ok) begin
          step_peaks[n] = '{12'(r), 10'(c - 1), 1'b0};
          n++;
        end
      end
      if (c == cols - 1) begin
        ok = 1'b1;
        if (c >= 1 && x < left_cur) ok = 1'b0;
        if (r >= 1 && x < up) ok = 1'b0;
        if (ok) begin
          step_peaks[n] = '{12'(r), 10'(c), 1'b0};
          n++;
        end
      end
    end
    if (n > 0) step_peaks[n - 1].last = 1'b1;
    if (r >= 1) two_back[c] = up;
    prev_line[c] = x;
    left_up  = up;
    left_cur = x;
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // predict on input transfers, then check output transfers, in one process
  always @(posedge clk) begin : scoreboard
    int             n;
    mlmf_pkg::res_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_addr == mlmf_pkg::REG_FRAME_ROWS) begin
          rows_reg = cfg_wdata[mlmf_pkg::ROWS_CFG_W-1:0];
        end else begin
          cols_reg = cfg_wdata[mlmf_pkg::COLS_CFG_W-1:0];
        end
        row_pos = 0;
        col_pos = 0;
      end
      if (in_tvalid && in_tready) begin
        find_peaks(in_tdata, n);
        if (typed_on) begin
          peak_fifo.push_back(typed_hit);
          typed_on = 1'b0;
        end else begin
          for (int k = 0; k < n; k++) peak_fifo.push_back(step_peaks[k]);
        end
      end
      if (out_tvalid && out_tready) begin
        if (peak_fifo.size() == 0) begin
          $display("%0t: peak with none expected: row %0d col %0d", $time,
                   out_tdata[mlmf_pkg::ROW_W-1:0],
                   out_tdata[mlmf_pkg::ROW_W +: mlmf_pkg::COL_OUT_W]);
          err_cnt++;
        end else begin
          want = peak_fifo.pop_front();
          if (out_tdata[mlmf_pkg::ROW_W-1:0] !== want.row) begin
            $display("%0t: peak_row expected %0d actual %0d", $time,
                     want.row, out_tdata[mlmf_pkg::ROW_W-1:0]);
            err_cnt++;
          end
          if (out_tdata[mlmf_pkg::ROW_W +: mlmf_pkg::COL_OUT_W] !== want.col) begin
            $display("%0t: peak_col expected %0d actual %0d", $time,
                     want.col, out_tdata[mlmf_pkg::ROW_W +: mlmf_pkg::COL_OUT_W]);
            err_cnt++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time,
                     want.last, out_tlast);
            err_cnt++;
          end
          if (out_tdata[mlmf_pkg::OUT_TDATA_W-1 -: mlmf_pkg::OUT_PAD_W] !== '0) begin
            $display("%0t: tdata pad expected 0 actual %0h", $time,
                     out_tdata[mlmf_pkg::OUT_TDATA_W-1 -: mlmf_pkg::OUT_PAD_W]);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= steady_run || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic [15:0] value, input bit typed,
                             input mlmf_pkg::res_t hit);
    @(negedge clk);
    while (!steady_run && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    typed_on  = typed;
    typed_hit = hit;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (peak_fifo.size() != 0) @(negedge clk);
  endtask

  // only between bursts, once the output side has gone quiet
  task automatic write_reg(input logic [mlmf_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [mlmf_pkg::CFG_DATA_W-1:0] val);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    logic [15:0] edges [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    case ($urandom_range(0, 3))
      0:       return edges[$urandom_range(0, 3)];
      1, 2:    return 16'($signed($urandom_range(0, 4)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [mlmf_pkg::CFG_DATA_W-1:0] rows_w, cols_w;
    int n_items;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        write_reg(plan[i].addr, plan[i].value[mlmf_pkg::CFG_DATA_W-1:0]);
      end else begin
        send_sample(plan[i].value, plan[i].typed, plan[i].hit);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        3: begin  // oversize row count, one column
          rows_w = 13'd8191;
          cols_w = 13'd1;
          n_items = 16;
        end
        6: begin  // no gaps on either side
          rows_w = 13'd3;
          cols_w = 13'd4;
          n_items = 24;
        end
        8: begin  // oversize column count, single row
          rows_w = 13'd1;
          cols_w = 13'd2047;
          n_items = 12;
        end
        default: begin
          rows_w = 13'($urandom_range(1, 5));
          cols_w = 13'($urandom_range(1, 6));
          n_items = int'(rows_w * cols_w) + int'($urandom_range(0, rows_w * cols_w));
        end
      endcase
      write_reg(mlmf_pkg::REG_FRAME_ROWS, rows_w);
      write_reg(mlmf_pkg::REG_FRAME_COLS, cols_w);
      steady_run = (ph == 6);
      for (int i = 0; i < n_items; i++) begin
        if (ph == 1 && i == n_items / 2) drain();
        send_sample(rand_sample(), 1'b0, '0);
      end
      steady_run = 1'b0;
    end

    drain();
    repeat (TAIL) @(negedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/mlmf_pkg.sv
sv/mlmf_cell.sv
sv/mlmf_linebuf.sv
sv/mlmf_outq.sv
sv/matrix_local_maximum_finder_unit.sv
verif/tb_matrix_local_maximum_finder_unit.sv
